@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the top-level unit; compiled out by ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

@@ sv/cfs_pkg.sv @@
// ----------------------------------------------------------------------------
// cfs_pkg
// Widths, register map and shared types of the circle fill scan generator.
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS_DEF = 24;

  localparam int CENTER_BITS = 12;
  localparam int RADIUS_BITS = 11;
  localparam int DIM_BITS    = 13;
  localparam int ADDR_BITS   = 24;
  localparam int PIXEL_BITS  = 24;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_RADIUS       = 3'd2,
    REG_FILL_VALUE   = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic done;
    logic last;
  } scan_flags_t;

endpackage

@@ sv/cfs_intf.sv @@
// ----------------------------------------------------------------------------
// cfs_intf
// Valid/ready channels: step input, pixel result and configuration write.
// ----------------------------------------------------------------------------
interface cfs_step_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface cfs_pixel_if;
  logic                          valid;
  logic                          ready;
  logic                          write_enable;
  logic [cfs_pkg::ADDR_BITS-1:0] pixel_address;
  logic [cfs_pkg::PIXEL_BITS-1:0] pixel_color;
  logic                          last;
  logic                          done_res;

  modport source (output valid, output write_enable, output pixel_address,
                  output pixel_color, output last, output done_res, input ready);
  modport sink   (input valid, input write_enable, input pixel_address,
                  input pixel_color, input last, input done_res, output ready);
endinterface

interface cfs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cfs_pkg::CFG_ADDR_BITS-1:0] addr;
  logic [cfs_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

@@ sv/cfs_scan_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfs_scan_ctrl
// Bounding box raster counters; registers the position of each accepted beat.
// ----------------------------------------------------------------------------
module cfs_scan_ctrl #(
  parameter int COORD_BITS = cfs_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            accept,
  input  logic                            restart,
  input  logic [cfs_pkg::RADIUS_BITS-1:0] radius,
  output logic                            pos_valid,
  output logic [COORD_BITS-1:0]           pos_row,
  output logic [COORD_BITS-1:0]           pos_col,
  output cfs_pkg::scan_flags_t            pos_flags
);

  localparam int LW = ((COORD_BITS > cfs_pkg::RADIUS_BITS + 1) ?
                       COORD_BITS : cfs_pkg::RADIUS_BITS + 1) + 1;

  logic [COORD_BITS-1:0] scan_row, scan_row_next;
  logic [COORD_BITS-1:0] scan_col, scan_col_next;
  logic                  finished, finished_next;

  logic [LW-1:0]         lim_wide;
  logic [COORD_BITS-1:0] limit;
  logic [COORD_BITS-1:0] row_c, col_c;
  logic                  fin_c, row_end, is_last;

  // box side limit 2r, saturated to the counter range
  assign lim_wide = LW'(radius) << 1;
  assign limit    = (lim_wide > LW'({COORD_BITS{1'b1}})) ? '1 : lim_wide[COORD_BITS-1:0];

  assign row_c   = (accept && restart) ? '0 : scan_row;
  assign col_c   = (accept && restart) ? '0 : scan_col;
  assign fin_c   = (accept && restart) ? 1'b0 : finished;
  assign row_end = col_c >= limit;
  assign is_last = row_end && (row_c >= limit);

  always_comb begin
    scan_row_next = scan_row;
    scan_col_next = scan_col;
    finished_next = finished;
    if (accept) begin
      scan_row_next = row_c;
      scan_col_next = col_c;
      finished_next = fin_c;
      if (!fin_c) begin
        if (is_last) begin
          finished_next = 1'b1;
        end else if (row_end) begin
          scan_col_next = '0;
          scan_row_next = row_c + 1'b1;
        end else begin
          scan_col_next = col_c + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row  <= '0;
      scan_col  <= '0;
      finished  <= 1'b1;
      pos_valid <= 1'b0;
    end else begin
      scan_row <= scan_row_next;
      scan_col <= scan_col_next;
      finished <= finished_next;
      if (en) begin
        pos_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_row        <= row_c;
      pos_col        <= col_c;
      pos_flags.done <= fin_c;
      pos_flags.last <= !fin_c && is_last;
    end
  end

endmodule

@@ sv/cfs_pixel_eval.sv @@
// ----------------------------------------------------------------------------
// cfs_pixel_eval
// Three-stage pipe: offsets and clipping, squares and row product, result.
// ----------------------------------------------------------------------------
module cfs_pixel_eval #(
  parameter int COORD_BITS = cfs_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = cfs_pkg::COLOR_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   pos_valid,
  input  logic [COORD_BITS-1:0]                  pos_row,
  input  logic [COORD_BITS-1:0]                  pos_col,
  input  cfs_pkg::scan_flags_t                   pos_flags,
  input  logic signed [cfs_pkg::CENTER_BITS-1:0] center_x,
  input  logic signed [cfs_pkg::CENTER_BITS-1:0] center_y,
  input  logic [cfs_pkg::RADIUS_BITS-1:0]        radius,
  input  logic [((COLOR_BITS < cfs_pkg::PIXEL_BITS) ?
                 COLOR_BITS : cfs_pkg::PIXEL_BITS)-1:0] fill_value,
  input  logic [cfs_pkg::DIM_BITS-1:0]           image_width,
  input  logic [cfs_pkg::DIM_BITS-1:0]           image_height,
  output logic                                   res_valid,
  output logic                                   write_enable,
  output logic [cfs_pkg::ADDR_BITS-1:0]          pixel_address,
  output logic [cfs_pkg::PIXEL_BITS-1:0]         pixel_color,
  output logic                                   last,
  output logic                                   done_res
);

  localparam int PW  = ((COORD_BITS > cfs_pkg::CENTER_BITS) ?
                        COORD_BITS : cfs_pkg::CENTER_BITS) + 2;
  localparam int SQW = 2 * PW;
  localparam int DW  = cfs_pkg::DIM_BITS;
  localparam int RRW = 2 * cfs_pkg::RADIUS_BITS;
  localparam int MW  = 2 * DW;

  logic signed [PW-1:0] cx_e, cy_e, r_e, col_e, row_e, wd_e, ht_e;
  logic signed [PW-1:0] px_c, py_c, dx_c, dy_c;

  // stage 2
  logic                 v2;
  logic signed [PW-1:0] px2, py2, dx2, dy2;
  logic                 in_img2;
  logic [RRW-1:0]       rr2;
  cfs_pkg::scan_flags_t flags2;

  // stage 3
  logic                 v3;
  logic [SQW-1:0]       dxsq3, dysq3;
  logic [MW-1:0]        rowoff3;
  logic [DW-1:0]        px3;
  logic                 in_img3;
  logic [RRW-1:0]       rr3;
  cfs_pkg::scan_flags_t flags3;

  logic [SQW:0]         dist3;
  logic                 we3;
  logic [MW-1:0]        addr3;

  assign cx_e  = PW'(center_x);
  assign cy_e  = PW'(center_y);
  assign r_e   = PW'(radius);
  assign col_e = PW'(pos_col);
  assign row_e = PW'(pos_row);
  assign wd_e  = PW'(image_width);
  assign ht_e  = PW'(image_height);

  assign px_c = cx_e - r_e + col_e;
  assign py_c = cy_e - r_e + row_e;
  assign dx_c = col_e - r_e;
  assign dy_c = row_e - r_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v2        <= pos_valid;
      v3        <= v2;
      res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px2     <= px_c;
      py2     <= py_c;
      dx2     <= dx_c;
      dy2     <= dy_c;
      in_img2 <= !px_c[PW-1] && !py_c[PW-1] && (px_c < wd_e) && (py_c < ht_e);
      rr2     <= RRW'(radius) * RRW'(radius);
      flags2  <= pos_flags;

      dxsq3   <= SQW'(dx2 * dx2);
      dysq3   <= SQW'(dy2 * dy2);
      rowoff3 <= MW'(py2[DW-1:0]) * MW'(image_width);
      px3     <= px2[DW-1:0];
      in_img3 <= in_img2;
      rr3     <= rr2;
      flags3  <= flags2;

      write_enable  <= we3;
      pixel_address <= we3 ? cfs_pkg::ADDR_BITS'(addr3) : '0;
      pixel_color   <= flags3.done ? '0 : cfs_pkg::PIXEL_BITS'(fill_value);
      last          <= flags3.last;
      done_res      <= flags3.done;
    end
  end

  assign dist3 = (SQW + 1)'(dxsq3) + (SQW + 1)'(dysq3);
  assign we3   = !flags3.done && in_img3 && (dist3 <= (SQW + 1)'(rr3));
  assign addr3 = rowoff3 + MW'(px3);

endmodule

@@ sv/circle_fill_scan_generator_unit.sv @@
// ----------------------------------------------------------------------------
// circle_fill_scan_generator_unit
// Filled circle rasterizer: raster scan of the circle's bounding box.
// ----------------------------------------------------------------------------
// Each step beat yields one pixel beat; a new step is taken every clock while
// the pixel channel keeps up, and the result passes in order through the
// position register, which loads at the accepting edge, then the offset and
// clipping stage, the multiplier stage (squared distance and row times width),
// and the compare and address result register. A stall on the pixel channel
// holds the whole pipe. The box is 2r+1 positions per side, scanned row by
// row; restart rewinds it, the final position carries last, and steps after
// it return done_res with no write. Configuration writes are taken at any
// time and apply at once; write them only while no step is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circle_fill_scan_generator_unit #(
  parameter int COORD_BITS = cfs_pkg::COORD_BITS_DEF,
  parameter int COLOR_BITS = cfs_pkg::COLOR_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  cfs_step_if.sink    step,
  cfs_pixel_if.source pixel,
  cfs_cfg_if.sink     cfg
);

  localparam int CW = (COLOR_BITS < cfs_pkg::PIXEL_BITS) ? COLOR_BITS : cfs_pkg::PIXEL_BITS;

  logic signed [cfs_pkg::CENTER_BITS-1:0] center_x, center_y;
  logic [cfs_pkg::RADIUS_BITS-1:0]        radius;
  logic [CW-1:0]                          fill_value;
  logic [cfs_pkg::DIM_BITS-1:0]           image_width, image_height;

  logic                 en, accept;
  logic                 s1_valid;
  logic [COORD_BITS-1:0] s1_row, s1_col;
  cfs_pkg::scan_flags_t s1_flags;

  // pipe advances unless a result waits on the output
  assign en         = !(pixel.valid && !pixel.ready);
  assign step.ready = en;
  assign accept     = step.valid && en;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      radius       <= '0;
      fill_value   <= '0;
      image_width  <= cfs_pkg::DIM_BITS'(1);
      image_height <= cfs_pkg::DIM_BITS'(1);
    end else if (cfg.valid) begin
      case (cfg.addr)
        cfs_pkg::REG_CENTER_X:     center_x     <= cfg.data[cfs_pkg::CENTER_BITS-1:0];
        cfs_pkg::REG_CENTER_Y:     center_y     <= cfg.data[cfs_pkg::CENTER_BITS-1:0];
        cfs_pkg::REG_RADIUS:       radius       <= cfg.data[cfs_pkg::RADIUS_BITS-1:0];
        cfs_pkg::REG_FILL_VALUE:   fill_value   <= cfg.data[CW-1:0];
        cfs_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg.data[cfs_pkg::DIM_BITS-1:0];
        cfs_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data[cfs_pkg::DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  cfs_scan_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .accept    (accept),
    .restart   (step.restart),
    .radius    (radius),
    .pos_valid (s1_valid),
    .pos_row   (s1_row),
    .pos_col   (s1_col),
    .pos_flags (s1_flags)
  );

  cfs_pixel_eval #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_eval (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .pos_valid     (s1_valid),
    .pos_row       (s1_row),
    .pos_col       (s1_col),
    .pos_flags     (s1_flags),
    .center_x      (center_x),
    .center_y      (center_y),
    .radius        (radius),
    .fill_value    (fill_value),
    .image_width   (image_width),
    .image_height  (image_height),
    .res_valid     (pixel.valid),
    .write_enable  (pixel.write_enable),
    .pixel_address (pixel.pixel_address),
    .pixel_color   (pixel.pixel_color),
    .last          (pixel.last),
    .done_res      (pixel.done_res)
  );

  `ASSERT_PROP(a_restart_scans, clk, rst,
               (step.valid && step.ready && step.restart) |=> (s1_valid && !s1_flags.done),
               "restart beat did not start a scan")
  `ASSERT_PROP(a_done_quiet, clk, rst,
               (pixel.valid && pixel.done_res) |-> (!pixel.write_enable && !pixel.last &&
               pixel.pixel_address == '0 && pixel.pixel_color == '0),
               "done beat carries a position")
  `ASSERT_NEVER(a_last_done, clk, rst, pixel.valid && pixel.last && pixel.done_res,
                "last and done on one beat")
  `ASSERT_PROP(a_idle_addr, clk, rst,
               (pixel.valid && !pixel.write_enable) |-> (pixel.pixel_address == '0),
               "address set without write")

endmodule
